[design/pwmrs_pkg.sv]
// Package for the PWM regulator setpoint block: sizes, codes, voltage table,
// and the transaction payload types. No dependencies.
package pwmrs_pkg;

    localparam int MAP_SIZE       = 25;
    localparam int PRESCALE_SHIFT = 1;

    localparam int UV_W      = 21;
    localparam int COEF_W    = 16;
    localparam int CLK_W     = 28;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 16;
    localparam int SEL_W     = 5;
    localparam int CODE_W    = 2;
    localparam int SCAN_W    = $clog2(MAP_SIZE);
    localparam int STEP_W    = $clog2(WORD_W);
    localparam int PCT_W     = 7;
    localparam int PROD_W    = CNT_W + PCT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [UV_W-1:0] TABLE_BASE_UV    = UV_W'(800000);
    localparam logic [UV_W-1:0] TABLE_STEP_UV    = UV_W'(25000);
    localparam logic [UV_W-1:0] PRESENT_RESET_UV = UV_W'(1100000);

    localparam logic [UV_W-1:0]   CEILING_RESET = UV_W'(1400000);
    localparam logic [COEF_W-1:0] COEF_RESET    = COEF_W'(455);
    localparam logic [CLK_W-1:0]  CLOCK_RESET   = CLK_W'(24000000);

    localparam logic [WORD_W-1:0] DUTY_DIV    = WORD_W'(10);
    localparam logic [WORD_W-1:0] PERCENT     = WORD_W'(100);
    localparam logic [WORD_W-1:0] LRC_DIVISOR = WORD_W'(64'(1000 * 1000) << PRESCALE_SHIFT);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM     = 2'd3;

    // result status
    localparam logic [CODE_W-1:0] ST_OK    = 2'd0;
    localparam logic [CODE_W-1:0] ST_RANGE = 2'd1;
    localparam logic [CODE_W-1:0] ST_DUTY  = 2'd2;
    localparam logic [CODE_W-1:0] ST_COEF  = 2'd3;

    // pin drive mode
    localparam logic [CODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [CODE_W-1:0] MODE_PWM  = 2'd1;
    localparam logic [CODE_W-1:0] MODE_HIGH = 2'd2;
    localparam logic [CODE_W-1:0] MODE_KEEP = 2'd3;

    typedef struct packed {
        logic [UV_W-1:0] request_min_uv;
        logic [UV_W-1:0] request_max_uv;
    } t_req;

    typedef struct packed {
        logic [CODE_W-1:0] status;
        logic [SEL_W-1:0]  selector_index;
        logic [UV_W-1:0]   chosen_uv;
        logic [CODE_W-1:0] drive_mode;
        logic [WORD_W-1:0] duty_percent;
        logic [CNT_W-1:0]  period_count;
        logic [CNT_W-1:0]  high_count;
    } t_rsp;

    // voltage table entry: evenly spaced from the base
    function automatic logic [UV_W-1:0] table_uv(input logic [SCAN_W-1:0] idx);
        logic [UV_W-1:0] step;
        step = TABLE_STEP_UV * UV_W'(idx);
        return TABLE_BASE_UV + step;
    endfunction

endpackage

[design/pwmrs_if.sv]
// Valid/ready channel interfaces for request and result transactions.
// Depends on pwmrs_pkg for the payload types.
interface pwmrs_req_if;
    logic              valid;
    logic              ready;
    pwmrs_pkg::t_req   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pwmrs_rsp_if;
    logic              valid;
    logic              ready;
    pwmrs_pkg::t_rsp   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/pwm_regulator_setpoint_core.sv]
// PWM regulator setpoint core: table lookup, bit-serial divider, result register.
// Depends on pwmrs_pkg and the channel interfaces in pwmrs_if.sv.
//
// Usage:
//   i_req carries a voltage window (min/max microvolts); o_rsp returns one result
//   per request: status, table index, chosen voltage, pin drive mode, duty and
//   the PWM period/high counts. Configuration registers are written through
//   i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the
//   block is idle, and the block itself does not enforce this.
// Flow: an out-of-table window skips the scan; otherwise one table entry per
//   cycle is scanned, up to MAP_SIZE, until one lies at or above the minimum.
//   Up to three divisions run on one shared restoring divider, one quotient bit
//   per cycle: duty, period count and high count.
// Throughput: one request at a time; i_req.ready is high while idle, also
//   while a finished result still waits in the output register.
// Reset: registers take their default values, the present voltage is
//   1100000 uV, no result is pending.
// Stall: a result stays in the output register until o_rsp.ready; a following
//   request is computed and then holds until the register frees up.
module pwm_regulator_setpoint_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pwmrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwmrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pwmrs_req_if.sink                            i_req,
    pwmrs_rsp_if.source                          o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] PH_DUTY = 2'd0;
    localparam logic [1:0] PH_LRC  = 2'd1;
    localparam logic [1:0] PH_HRC  = 2'd2;

    localparam int UV_W   = pwmrs_pkg::UV_W;
    localparam int WORD_W = pwmrs_pkg::WORD_W;
    localparam int CNT_W  = pwmrs_pkg::CNT_W;
    localparam int SCAN_W = pwmrs_pkg::SCAN_W;
    localparam int STEP_W = pwmrs_pkg::STEP_W;
    localparam int PCT_W  = pwmrs_pkg::PCT_W;
    localparam int PROD_W = pwmrs_pkg::PROD_W;

    // configuration
    logic [UV_W-1:0]                 r_ceil;
    logic [pwmrs_pkg::COEF_W-1:0]    r_coef;
    logic [pwmrs_pkg::CLK_W-1:0]     r_clk_hz;
    logic                            r_pwm;

    // control
    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic                            r_rsp_valid;
    logic [UV_W-1:0]                 r_present_uv;

    // work registers
    logic [1:0]                      r_phase;
    logic [UV_W-1:0]                 r_lo;
    logic [SCAN_W-1:0]               r_idx;
    logic                            r_hit;
    logic [pwmrs_pkg::CODE_W-1:0]    r_status;
    logic [pwmrs_pkg::CODE_W-1:0]    r_mode;
    logic [WORD_W-1:0]               r_duty;
    logic [CNT_W-1:0]                r_lrc;
    logic [CNT_W-1:0]                r_hrc;
    logic [WORD_W-1:0]               r_rem;
    logic [WORD_W-1:0]               r_quo;
    logic [WORD_W-1:0]               r_div;
    logic [STEP_W-1:0]               r_cnt;
    pwmrs_pkg::t_rsp                 r_rsp;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_out_of_table;
    logic [UV_W-1:0]                 w_tab;
    logic                            w_tab_hit;
    logic                            w_scan_last;
    logic [WORD_W:0]                 w_rem_sh;
    logic                            w_ge;
    logic [WORD_W:0]                 w_rem_sub;
    logic [CNT_W-1:0]                w_lrc_now;
    logic [PROD_W-1:0]               w_prod;
    logic [CNT_W-1:0]                w_hrc_now;
    logic [WORD_W-1:0]               w_duty_div;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_rsp_valid || o_rsp.ready;

    assign w_out_of_table =
        (i_req.payload.request_min_uv < pwmrs_pkg::table_uv(SCAN_W'(0))) ||
        (i_req.payload.request_max_uv >
         pwmrs_pkg::table_uv(SCAN_W'(pwmrs_pkg::MAP_SIZE - 1)));

    assign w_tab       = pwmrs_pkg::table_uv(r_idx);
    assign w_tab_hit   = (w_tab >= r_lo);
    assign w_scan_last = (r_idx == SCAN_W'(pwmrs_pkg::MAP_SIZE - 1));

    // restoring division, one quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_quo[WORD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});

    assign w_lrc_now  = (r_quo == '0) ? CNT_W'(1) : r_quo[CNT_W-1:0];
    assign w_prod     = PROD_W'(w_lrc_now) * PROD_W'(r_duty[PCT_W-1:0]);
    assign w_hrc_now  = (r_quo == '0) ? CNT_W'(1) : r_quo[CNT_W-1:0];
    assign w_duty_div = WORD_W'(r_coef) * pwmrs_pkg::DUTY_DIV;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_out_of_table ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tab_hit) begin
                    n_state = (r_pwm && (r_coef != '0)) ? S_DIV : S_DONE;
                end else if (w_scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_phase == PH_HRC) begin
                    n_state = S_DONE;
                end else if (r_phase == PH_LRC) begin
                    n_state = S_DIV;
                end else if ((r_quo != '0) && (r_quo < pwmrs_pkg::PERCENT)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rsp_valid  <= 1'b0;
            r_present_uv <= pwmrs_pkg::PRESENT_RESET_UV;
            r_ceil       <= pwmrs_pkg::CEILING_RESET;
            r_coef       <= pwmrs_pkg::COEF_RESET;
            r_clk_hz     <= pwmrs_pkg::CLOCK_RESET;
            r_pwm        <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (r_state == S_SCAN && w_tab_hit) begin
                r_present_uv <= w_tab;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pwmrs_pkg::CFG_CEILING: r_ceil   <= i_cfg_data[UV_W-1:0];
                    pwmrs_pkg::CFG_COEF:    r_coef   <= i_cfg_data[pwmrs_pkg::COEF_W-1:0];
                    pwmrs_pkg::CFG_CLOCK:   r_clk_hz <= i_cfg_data[pwmrs_pkg::CLK_W-1:0];
                    pwmrs_pkg::CFG_PWM:     r_pwm    <= i_cfg_data[0];
                    default:                r_pwm    <= r_pwm;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_lo     <= i_req.payload.request_min_uv;
                    r_idx    <= '0;
                    r_hit    <= 1'b0;
                    r_status <= pwmrs_pkg::ST_RANGE;
                    r_mode   <= pwmrs_pkg::MODE_KEEP;
                    r_duty   <= '0;
                    r_lrc    <= '0;
                    r_hrc    <= '0;
                end
            end
            S_SCAN: begin
                if (w_tab_hit) begin
                    r_hit <= 1'b1;
                    if (!r_pwm) begin
                        r_status <= pwmrs_pkg::ST_OK;
                    end else if (r_coef == '0) begin
                        r_status <= pwmrs_pkg::ST_COEF;
                    end else begin
                        // (ceiling - voltage) / coef / 10 == (ceiling - voltage) / (10 * coef)
                        r_phase <= PH_DUTY;
                        r_rem   <= '0;
                        r_quo   <= WORD_W'(r_ceil) - WORD_W'(w_tab);
                        r_div   <= w_duty_div;
                        r_cnt   <= STEP_W'(WORD_W - 1);
                    end
                end else if (!w_scan_last) begin
                    r_idx <= r_idx + SCAN_W'(1);
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? w_rem_sub[WORD_W-1:0] : w_rem_sh[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], w_ge};
                r_cnt <= r_cnt - STEP_W'(1);
            end
            S_EVAL: begin
                r_rem <= '0;
                r_cnt <= STEP_W'(WORD_W - 1);
                unique case (r_phase)
                    PH_DUTY: begin
                        r_duty <= r_quo;
                        if (r_quo == '0) begin
                            r_status <= pwmrs_pkg::ST_OK;
                            r_mode   <= pwmrs_pkg::MODE_LOW;
                        end else if (r_quo < pwmrs_pkg::PERCENT) begin
                            // period count: clock / (1 MHz << prescale)
                            r_phase <= PH_LRC;
                            r_quo   <= WORD_W'(r_clk_hz);
                            r_div   <= pwmrs_pkg::LRC_DIVISOR;
                        end else if (r_quo == pwmrs_pkg::PERCENT) begin
                            r_status <= pwmrs_pkg::ST_OK;
                            r_mode   <= pwmrs_pkg::MODE_HIGH;
                        end else begin
                            r_status <= pwmrs_pkg::ST_DUTY;
                        end
                    end
                    PH_LRC: begin
                        r_lrc   <= w_lrc_now;
                        r_phase <= PH_HRC;
                        r_quo   <= WORD_W'(w_prod);
                        r_div   <= pwmrs_pkg::PERCENT;
                    end
                    PH_HRC: begin
                        r_hrc    <= w_hrc_now;
                        r_status <= pwmrs_pkg::ST_OK;
                        r_mode   <= pwmrs_pkg::MODE_PWM;
                    end
                    default: r_phase <= PH_DUTY;
                endcase
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_rsp.status         <= r_status;
                    r_rsp.selector_index <= r_hit ? pwmrs_pkg::SEL_W'(r_idx) : '0;
                    r_rsp.chosen_uv      <= r_hit ? r_present_uv : '0;
                    r_rsp.drive_mode     <= r_mode;
                    r_rsp.duty_percent   <= r_duty;
                    r_rsp.period_count   <= r_lrc;
                    r_rsp.high_count     <= r_hrc;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

[design/pwmrs_checker.sv]
// Port-level checks for pwm_regulator_setpoint_core, attached by bind.
// Depends on pwmrs_pkg for status and drive mode codes.
module pwmrs_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  pwmrs_pkg::t_rsp            i_rsp
);

    // result holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped before taken");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted during computation");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == pwmrs_pkg::ST_RANGE) |->
        (i_rsp.drive_mode == pwmrs_pkg::MODE_KEEP) && (i_rsp.chosen_uv == '0) &&
        (i_rsp.selector_index == '0))
        else $error("out-of-table result carries a selection");

    a_pwm_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.drive_mode == pwmrs_pkg::MODE_PWM) |->
        (i_rsp.status == pwmrs_pkg::ST_OK) && (i_rsp.high_count != '0) &&
        (i_rsp.high_count <= i_rsp.period_count))
        else $error("bad PWM counts");

    a_static_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && ((i_rsp.drive_mode == pwmrs_pkg::MODE_LOW) ||
        (i_rsp.drive_mode == pwmrs_pkg::MODE_HIGH)) |->
        (i_rsp.period_count == '0) && (i_rsp.high_count == '0))
        else $error("static pin drive with nonzero counts");

endmodule

bind pwm_regulator_setpoint_core pwmrs_checker u_pwmrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

[sim/pwmrs_setpoint_checker.sv]
// Checker for the PWM regulator setpoint core: watches the config port and both
// channels, predicts each result and compares it field by field.
// Depends on pwmrs_pkg and the channel interfaces in pwmrs_if.sv.
module pwmrs_setpoint_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pwmrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pwmrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pwmrs_req_if                             i_req,
    pwmrs_rsp_if                             i_rsp,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UV_W     = pwmrs_pkg::UV_W;
    localparam int WORD_W   = pwmrs_pkg::WORD_W;
    localparam int CNT_W    = pwmrs_pkg::CNT_W;
    localparam int SEL_W    = pwmrs_pkg::SEL_W;
    localparam int COEF_W   = pwmrs_pkg::COEF_W;
    localparam int CLK_W    = pwmrs_pkg::CLK_W;
    localparam int MAP_SIZE = pwmrs_pkg::MAP_SIZE;

    localparam logic [UV_W-1:0]   ENTRY_BASE_UV = UV_W'(800000);
    localparam logic [UV_W-1:0]   ENTRY_STEP_UV = UV_W'(25000);
    localparam logic [WORD_W-1:0] HZ_PER_MHZ    = WORD_W'(1000000);
    localparam logic [WORD_W-1:0] FULL_DUTY     = WORD_W'(100);
    localparam logic [WORD_W-1:0] DUTY_SCALE    = WORD_W'(10);

    logic [UV_W-1:0]   ceiling_uv;
    logic [COEF_W-1:0] duty_coef;
    logic [CLK_W-1:0]  pwm_clock_hz;
    logic              pwm_on;

    pwmrs_pkg::t_rsp pending_setpoints[$];

    function automatic logic [UV_W-1:0] entry_uv(int idx);
        return ENTRY_BASE_UV + UV_W'(idx) * ENTRY_STEP_UV;
    endfunction

    // expected result for one window
    function automatic pwmrs_pkg::t_rsp predict_setpoint(pwmrs_pkg::t_req win);
        pwmrs_pkg::t_rsp   res;
        int                pick;
        logic [UV_W-1:0]   uv;
        logic [WORD_W-1:0] duty, lrc, hrc;
        res = '0;
        res.status = pwmrs_pkg::ST_RANGE;
        res.drive_mode = pwmrs_pkg::MODE_KEEP;
        pick = -1;
        if (win.request_min_uv >= entry_uv(0) &&
            win.request_max_uv <= entry_uv(MAP_SIZE-1)) begin
            for (int i = 0; i < MAP_SIZE; i++) begin
                if (pick < 0 && entry_uv(i) >= win.request_min_uv)
                    pick = i;
            end
        end
        // min above every entry falls out as a range error too
        if (pick < 0)
            return res;
        uv = entry_uv(pick);
        res.status = pwmrs_pkg::ST_OK;
        res.selector_index = SEL_W'(pick);
        res.chosen_uv = uv;
        if (!pwm_on)
            return res;
        if (duty_coef == '0) begin
            res.status = pwmrs_pkg::ST_COEF;
            return res;
        end
        // wraps when the voltage sits above the ceiling
        duty = (WORD_W'(ceiling_uv) - WORD_W'(uv)) / WORD_W'(duty_coef) / DUTY_SCALE;
        res.duty_percent = duty;
        if (duty == '0) begin
            res.drive_mode = pwmrs_pkg::MODE_LOW;
        end else if (duty < FULL_DUTY) begin
            lrc = (WORD_W'(pwm_clock_hz) / HZ_PER_MHZ) >> pwmrs_pkg::PRESCALE_SHIFT;
            if (lrc == '0)
                lrc = WORD_W'(1);
            hrc = lrc * duty / FULL_DUTY;
            if (hrc == '0)
                hrc = WORD_W'(1);
            res.drive_mode = pwmrs_pkg::MODE_PWM;
            res.period_count = CNT_W'(lrc);
            res.high_count = CNT_W'(hrc);
        end else if (duty == FULL_DUTY) begin
            res.drive_mode = pwmrs_pkg::MODE_HIGH;
        end else begin
            res.status = pwmrs_pkg::ST_DUTY;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("%0d ns: %s got %0d, expected %0d", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic compare_setpoint(pwmrs_pkg::t_rsp got, pwmrs_pkg::t_rsp want);
        if (got.status !== want.status)
            report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
        if (got.selector_index !== want.selector_index)
            report_mismatch("selector_index", WORD_W'(got.selector_index),
                            WORD_W'(want.selector_index));
        if (got.chosen_uv !== want.chosen_uv)
            report_mismatch("chosen_uv", WORD_W'(got.chosen_uv), WORD_W'(want.chosen_uv));
        if (got.drive_mode !== want.drive_mode)
            report_mismatch("drive_mode", WORD_W'(got.drive_mode), WORD_W'(want.drive_mode));
        if (got.duty_percent !== want.duty_percent)
            report_mismatch("duty_percent", got.duty_percent, want.duty_percent);
        if (got.period_count !== want.period_count)
            report_mismatch("period_count", WORD_W'(got.period_count),
                            WORD_W'(want.period_count));
        if (got.high_count !== want.high_count)
            report_mismatch("high_count", WORD_W'(got.high_count), WORD_W'(want.high_count));
    endtask

    always @(posedge i_clk) begin : monitor
        pwmrs_pkg::t_rsp want;
        if (!i_rst_n) begin
            ceiling_uv = pwmrs_pkg::CEILING_RESET;
            duty_coef = pwmrs_pkg::COEF_RESET;
            pwm_clock_hz = pwmrs_pkg::CLOCK_RESET;
            pwm_on = 1'b1;
            pending_setpoints.delete();
        end else begin
            // a result never leaves in the cycle its request is accepted, so pop first
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (pending_setpoints.size() == 0) begin
                    report_mismatch("unexpected transaction, chosen_uv",
                                    WORD_W'(i_rsp.payload.chosen_uv), '0);
                end else begin
                    want = pending_setpoints.pop_front();
                    compare_setpoint(i_rsp.payload, want);
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                pending_setpoints.push_back(predict_setpoint(i_req.payload));
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    pwmrs_pkg::CFG_CEILING: ceiling_uv = i_cfg_data[UV_W-1:0];
                    pwmrs_pkg::CFG_COEF:    duty_coef = i_cfg_data[COEF_W-1:0];
                    pwmrs_pkg::CFG_CLOCK:   pwm_clock_hz = i_cfg_data[CLK_W-1:0];
                    pwmrs_pkg::CFG_PWM:     pwm_on = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_outstanding = pending_setpoints.size();
    end

endmodule

[sim/testbench.sv]
// Top of the setpoint core testbench: clock, reset, config writes, request and
// result traffic with random gaps, and the verdict. Uses pwmrs_setpoint_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UV_W       = pwmrs_pkg::UV_W;
    localparam int COEF_W     = pwmrs_pkg::COEF_W;
    localparam int CLK_W      = pwmrs_pkg::CLK_W;
    localparam int CFG_IDX_W  = pwmrs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pwmrs_pkg::CFG_DATA_W;
    localparam int MAP_SIZE   = pwmrs_pkg::MAP_SIZE;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int HOLD_AT_ITEM    = 450;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 150;
    localparam int UV_MAX          = 2**UV_W - 1;
    localparam int TABLE_LO_UV     = 800000;
    localparam int TABLE_HI_UV     = 1400000;
    localparam int TABLE_STEP_UV   = 25000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    item_no;

    pwmrs_req_if req_ch();
    pwmrs_rsp_if rsp_ch();

    pwm_regulator_setpoint_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    pwmrs_setpoint_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
    endtask

    task automatic apply_setting(logic [UV_W-1:0] ceiling, logic [COEF_W-1:0] coef,
                                 logic [CLK_W-1:0] clock_hz, logic pwm);
        write_reg(pwmrs_pkg::CFG_CEILING, CFG_DATA_W'(ceiling));
        write_reg(pwmrs_pkg::CFG_COEF, CFG_DATA_W'(coef));
        write_reg(pwmrs_pkg::CFG_CLOCK, CFG_DATA_W'(clock_hz));
        write_reg(pwmrs_pkg::CFG_PWM, CFG_DATA_W'(pwm));
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_window(logic [UV_W-1:0] lo, logic [UV_W-1:0] hi);
        int              gap;
        int              k;
        pwmrs_pkg::t_req win;
        k = $urandom_range(0, 99);
        // every 128 items a stretch goes back to back
        if (item_no % 128 < 20 || k < 55)
            gap = 0;
        else if (k < 88)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        item_no++;
        win.request_min_uv = lo;
        win.request_max_uv = hi;
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.payload <= win;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // mostly windows inside the table, some inverted, some raw noise and edges
    task automatic send_random();
        logic [UV_W-1:0] lo, hi;
        int              k;
        k = $urandom_range(0, 99);
        if (k < 70) begin
            if (k < 35)
                lo = UV_W'(TABLE_LO_UV + TABLE_STEP_UV * $urandom_range(0, MAP_SIZE - 1));
            else
                lo = UV_W'($urandom_range(TABLE_LO_UV, TABLE_HI_UV));
            hi = UV_W'($urandom_range(lo, TABLE_HI_UV));
        end else if (k < 80) begin
            lo = UV_W'($urandom_range(TABLE_LO_UV, TABLE_HI_UV));
            hi = UV_W'($urandom_range(TABLE_LO_UV, lo));
        end else if (k < 95) begin
            lo = UV_W'($urandom_range(0, UV_MAX));
            hi = UV_W'($urandom_range(0, UV_MAX));
        end else begin
            lo = UV_W'($urandom_range(TABLE_LO_UV - 10, TABLE_LO_UV + 10));
            hi = UV_W'($urandom_range(TABLE_HI_UV - 10, TABLE_HI_UV + 10));
        end
        send_window(lo, hi);
    endtask

    task automatic settle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic hold_ready(logic level, int cycles);
        @(negedge i_clk);
        rsp_ch.ready <= level;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // result side: random stalls, one long hold-off while requests keep coming
    initial begin
        int k;
        bit held;
        rsp_ch.ready = 1'b0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            k = $urandom_range(0, 99);
            if (!held && item_no >= HOLD_AT_ITEM) begin
                held = 1'b1;
                hold_ready(1'b0, HOLD_CYCLES);
            end else if (k < 60) begin
                hold_ready(1'b1, $urandom_range(1, 8));
            end else if (k < 85) begin
                hold_ready(1'b0, $urandom_range(1, 3));
            end else if (k < 95) begin
                hold_ready(1'b1, $urandom_range(30, 80));
            end else begin
                hold_ready(1'b0, $urandom_range(20, 80));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        item_no = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(UV_W'(1400000), COEF_W'(455), CLK_W'(24000000), 1'b1);
        send_window(UV_W'(0), UV_W'(0));
        send_window(UV_W'(UV_MAX), UV_W'(UV_MAX));
        send_window(UV_W'(TABLE_LO_UV - 1), UV_W'(1000000));
        send_window(UV_W'(TABLE_LO_UV), UV_W'(TABLE_HI_UV + 1));
        send_window(UV_W'(TABLE_LO_UV), UV_W'(TABLE_HI_UV));      // duty above 100
        send_window(UV_W'(TABLE_HI_UV), UV_W'(TABLE_HI_UV));      // duty 0, pin low
        send_window(UV_W'(1000001), UV_W'(1100000));              // PWM running
        send_window(UV_W'(TABLE_HI_UV), UV_W'(TABLE_LO_UV));      // inverted window, entry found
        send_window(UV_W'(TABLE_HI_UV + 1), UV_W'(900000));       // min above every entry
        send_window(UV_W'(UV_MAX), UV_W'(0));
        send_window(UV_W'(1375000), UV_W'(1375000));
        send_window(UV_W'(950000), UV_W'(1000000));
        send_window(UV_W'(1000000), UV_W'(UV_MAX));

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: apply_setting(UV_W'(1400000), COEF_W'(455), CLK_W'(24000000), 1'b1);
                1: apply_setting(UV_W'(1400000), COEF_W'(455), CLK_W'(24000000), 1'b0);
                2: apply_setting(UV_W'(1400000), '0, CLK_W'(24000000), 1'b1);
                3: apply_setting(UV_W'(2000000), '1, CLK_W'(200000000), 1'b1);
                4: apply_setting('0, COEF_W'(1), CLK_W'(1), 1'b1);
                // 250 uV/percent: one table step is exactly full duty
                5: apply_setting(UV_W'(1400000), COEF_W'(25), CLK_W'(1999999), 1'b1);
                // high count rounds to zero here and gets clamped
                6: apply_setting(UV_W'(1400000), COEF_W'(2500), CLK_W'(1000000), 1'b1);
                7: apply_setting('1, '1, '1, 1'b1);
                default: apply_setting(UV_W'($urandom_range(900000, 2000000)),
                                       COEF_W'($urandom_range(1, 3000)),
                                       CLK_W'($urandom_range(1, 200000000)),
                                       logic'($urandom_range(0, 7) != 0));
            endcase
            repeat (ITEMS_PER_PHASE) send_random();
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
